// ===== hw/rtl/ibmw_pkg.sv =====
// ibmw_pkg: shared types, codes and helpers for the indirect block map walker
// no dependencies; used by the interfaces and every module of the walker

package ibmw_pkg;

	localparam int WORD_W   = 32;
	localparam int ENTRY_W  = 10;
	localparam int LOG2_W   = 4;
	localparam int STATUS_W = 2;
	localparam int ADDR_W   = 3;
	localparam int DATA_W   = 32;

	localparam logic [LOG2_W-1:0] LOG2_MIN = 4'd8;
	localparam logic [LOG2_W-1:0] LOG2_RESET = 4'd8;

	// register word index within the config space
	localparam logic REG_PPB_LOG2 = 1'b0;

	typedef enum logic {
		OP_REQUEST = 1'b0,
		OP_POINTER = 1'b1
	} op_t;

	typedef enum logic {
		KIND_READ = 1'b0,
		KIND_DONE = 1'b1
	} kind_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_MAPPED = 2'd0,
		ST_HOLE   = 2'd1,
		ST_RANGE  = 2'd2,
		ST_RD_ERR = 2'd3
	} status_t;

	// effective table geometry, derived at reset and once per register write
	typedef struct packed {
		logic [LOG2_W-1:0] eff_l;
		logic [WORD_W-1:0] lim1;
		logic [WORD_W-1:0] lim2;
		logic [WORD_W-1:0] lim3;
	} cfg_t;

	// split of one file block number
	typedef struct packed {
		logic                      beyond;
		logic [1:0]                level;
		logic [ENTRY_W-1:0]        entry0;
		logic [3:1][ENTRY_W-1:0]   idx;
	} decode_t;

	// one result beat plus its presence flag
	typedef struct packed {
		logic               has;
		kind_t              kind;
		logic [WORD_W-1:0]  table_block;
		logic [ENTRY_W-1:0] entry_index;
		logic [WORD_W-1:0]  disk_blk;
		status_t            status;
	} result_t;

	// clamp log2 pointers per block and derive the level limits
	function automatic cfg_t make_cfg(logic [LOG2_W-1:0] raw, logic [WORD_W-1:0] dc,
			logic [LOG2_W-1:0] max_l);
		logic [LOG2_W-1:0] l;
		logic [5:0]        l3;
		cfg_t              c;
		l = raw;
		if (l < LOG2_MIN) l = LOG2_MIN;
		if (l > max_l) l = max_l;
		l3 = 6'(l) + 6'({l, 1'b0});
		c.eff_l = l;
		c.lim1  = dc + (WORD_W'(1) << l);
		c.lim2  = c.lim1 + (WORD_W'(1) << {l, 1'b0});
		c.lim3  = c.lim2 + (WORD_W'(1) << l3);
		return c;
	endfunction

endpackage

// ===== hw/rtl/ibmw_item_if.sv =====
// ibmw_item_if: input channel of the walker, valid/ready plus item payload
// depends on ibmw_pkg for field widths

interface ibmw_item_if;
	logic                           valid;
	logic                           ready;
	logic                           op;
	logic [ibmw_pkg::WORD_W-1:0]    logical_blk;
	logic [ibmw_pkg::WORD_W-1:0]    pointer_word;
	logic                           read_failed;

	modport source (output valid, output op, output logical_blk, output pointer_word,
		output read_failed, input ready);
	modport sink (input valid, input op, input logical_blk, input pointer_word,
		input read_failed, output ready);
endinterface

// ===== hw/rtl/ibmw_result_if.sv =====
// ibmw_result_if: output channel of the walker, valid/ready plus result payload
// depends on ibmw_pkg for field widths

interface ibmw_result_if;
	logic                           valid;
	logic                           ready;
	logic                           kind;
	logic [ibmw_pkg::WORD_W-1:0]    table_block;
	logic [ibmw_pkg::ENTRY_W-1:0]   entry_index;
	logic [ibmw_pkg::WORD_W-1:0]    disk_blk;
	logic [ibmw_pkg::STATUS_W-1:0]  status;

	modport source (output valid, output kind, output table_block, output entry_index,
		output disk_blk, output status, input ready);
	modport sink (input valid, input kind, input table_block, input entry_index,
		input disk_blk, input status, output ready);
endinterface

// ===== hw/rtl/ibmw_cfg.sv =====
// ibmw_cfg: APB-style register port holding log2 pointers per block
// depends on ibmw_pkg; derives clamped geometry at write time

module ibmw_cfg #(
	parameter int DIRECT_COUNT = 12,
	parameter int INDEX_BITS   = 10
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [ibmw_pkg::ADDR_W-1:0]   paddr,
	input  logic [ibmw_pkg::DATA_W-1:0]   pwdata,
	output logic [ibmw_pkg::DATA_W-1:0]   prdata,
	output logic                          pready,
	output ibmw_pkg::cfg_t                cfg
);
	import ibmw_pkg::*;

	localparam logic [WORD_W-1:0] DC_W  = WORD_W'(DIRECT_COUNT);
	localparam logic [LOG2_W-1:0] MAX_L = LOG2_W'(INDEX_BITS);

	logic [LOG2_W-1:0] ppb_log2_q;
	cfg_t              cfg_q;
	logic              wr_en;

	// write strobe on the access phase
	assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_PPB_LOG2);
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ppb_log2_q <= LOG2_RESET;
			cfg_q      <= make_cfg(LOG2_RESET, DC_W, MAX_L);
		end else if (wr_en) begin
			ppb_log2_q <= pwdata[LOG2_W-1:0];
			cfg_q      <= make_cfg(pwdata[LOG2_W-1:0], DC_W, MAX_L);
		end
	end

	// read back the raw register value
	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_PPB_LOG2) prdata = DATA_W'(ppb_log2_q);
	end

	assign cfg = cfg_q;

endmodule

// ===== hw/rtl/ibmw_decode.sv =====
// ibmw_decode: splits a file block number into walk level and table indices
// depends on ibmw_pkg; pure combinational logic fed by the geometry registers

module ibmw_decode #(
	parameter int DIRECT_COUNT = 12
) (
	input  ibmw_pkg::cfg_t                cfg,
	input  logic [ibmw_pkg::WORD_W-1:0]   logical_blk,
	output ibmw_pkg::decode_t             dec
);
	import ibmw_pkg::*;

	localparam logic [WORD_W-1:0]  DC_W    = WORD_W'(DIRECT_COUNT);
	localparam logic [ENTRY_W-1:0] DC_BASE = ENTRY_W'(DIRECT_COUNT - 1);

	logic               in_l0, in_l1, in_l2, in_l3;
	logic [WORD_W-1:0]  base;
	logic [WORD_W-1:0]  off;
	logic [WORD_W-1:0]  off_sh1;
	logic [WORD_W-1:0]  off_sh2;
	logic [ENTRY_W-1:0] mask;

	// range compares against precomputed limits
	assign in_l0 = logical_blk < DC_W;
	assign in_l1 = logical_blk < cfg.lim1;
	assign in_l2 = logical_blk < cfg.lim2;
	assign in_l3 = logical_blk < cfg.lim3;

	// offset inside the selected level
	always_comb begin
		priority if (in_l1) base = DC_W;
		else if (in_l2)     base = cfg.lim1;
		else                base = cfg.lim2;
	end

	assign off     = logical_blk - base;
	assign off_sh1 = off >> cfg.eff_l;
	assign off_sh2 = off >> {cfg.eff_l, 1'b0};
	assign mask    = (ENTRY_W'(1) << cfg.eff_l) - ENTRY_W'(1);

	// level and per-level indices
	always_comb begin
		dec        = '0;
		dec.beyond = !in_l3;
		priority if (in_l0) begin
			dec.level  = 2'd0;
			dec.entry0 = logical_blk[ENTRY_W-1:0];
		end else if (in_l1) begin
			dec.level  = 2'd1;
			dec.idx[1] = off[ENTRY_W-1:0] & mask;
		end else if (in_l2) begin
			dec.level  = 2'd2;
			dec.idx[1] = off_sh1[ENTRY_W-1:0] & mask;
			dec.idx[2] = off[ENTRY_W-1:0] & mask;
		end else begin
			dec.level  = 2'd3;
			dec.idx[1] = off_sh2[ENTRY_W-1:0] & mask;
			dec.idx[2] = off_sh1[ENTRY_W-1:0] & mask;
			dec.idx[3] = off[ENTRY_W-1:0] & mask;
		end
		if (!in_l0) dec.entry0 = DC_BASE + ENTRY_W'(dec.level);
	end

endmodule

// ===== hw/rtl/ibmw_walk.sv =====
// ibmw_walk: walk state, index stack and result selection for one item
// depends on ibmw_pkg; consumes the decode of the staged request

module ibmw_walk #(
	parameter int INDEX_BITS = 10,
	parameter int MAX_LEVEL  = 3
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          adv,
	input  logic                          op,
	input  logic [ibmw_pkg::WORD_W-1:0]   pointer_word,
	input  logic                          read_failed,
	input  ibmw_pkg::decode_t             dec,
	output ibmw_pkg::result_t             res
);
	import ibmw_pkg::*;

	localparam int STK_W = (MAX_LEVEL + 1 > 1) ? $clog2(MAX_LEVEL + 1) : 1;
	localparam logic [1:0] MAX_LVL = 2'(MAX_LEVEL);

	logic                  walk_busy_q;
	logic [1:0]            walk_depth_q;
	logic [1:0]            steps_done_q;
	logic [INDEX_BITS-1:0] stack_q [0:MAX_LEVEL];

	logic                  is_req;
	logic                  start;
	logic                  walk_end;
	logic                  step_on;
	logic [1:0]            steps_next;

	assign is_req     = (op == OP_REQUEST);
	assign start      = is_req && !dec.beyond && (dec.level <= MAX_LVL);
	assign steps_next = steps_done_q + 2'd1;

	// result for the staged beat
	always_comb begin
		res      = '0;
		walk_end = 1'b0;
		step_on  = 1'b0;
		res.kind   = KIND_DONE;
		res.status = ST_MAPPED;
		if (is_req) begin
			res.has = 1'b1;
			if (start) begin
				res.kind        = KIND_READ;
				res.entry_index = dec.entry0;
			end else begin
				res.status = ST_RANGE;
			end
		end else if (walk_busy_q) begin
			res.has  = 1'b1;
			walk_end = 1'b1;
			priority if (read_failed) begin
				res.status = ST_RD_ERR;
			end else if (pointer_word == '0) begin
				res.status = ST_HOLE;
			end else if (steps_done_q >= walk_depth_q) begin
				res.disk_blk = pointer_word;
			end else begin
				walk_end        = 1'b0;
				step_on         = 1'b1;
				res.kind        = KIND_READ;
				res.table_block = pointer_word;
				res.entry_index = ENTRY_W'(stack_q[STK_W'(steps_next)]);
			end
		end
	end

	// walk control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			walk_busy_q  <= 1'b0;
			walk_depth_q <= 2'd0;
			steps_done_q <= 2'd0;
		end else if (adv) begin
			if (is_req) begin
				walk_busy_q  <= start;
				walk_depth_q <= dec.level;
				steps_done_q <= 2'd0;
			end else if (walk_end) begin
				walk_busy_q <= 1'b0;
			end else if (step_on) begin
				steps_done_q <= steps_next;
			end
		end
	end

	// index stack, loaded by every request
	always_ff @(posedge clk) begin
		if (adv && is_req) begin
			stack_q[0] <= INDEX_BITS'(dec.entry0);
			for (int k = 1; k <= MAX_LEVEL; k++) begin
				stack_q[k] <= INDEX_BITS'(dec.idx[k]);
			end
		end
	end

endmodule

// ===== hw/rtl/indirect_block_map_walker_unit.sv =====
// Indirect block map walker: one item per cycle unless the output stalls; an item
// passes the input register, then the result register, to its result beat. The
// walk state updates as an item leaves the input register, so back-to-back items
// see each other's updates. A stalled result register holds one beat and the
// input register holds one more. No memory clearing pass follows reset. Depends
// on ibmw_pkg, ibmw_item_if, ibmw_result_if, ibmw_cfg, ibmw_decode and ibmw_walk.

module indirect_block_map_walker_unit #(
	parameter int DIRECT_COUNT = 12,
	parameter int INDEX_BITS   = 10,
	parameter int MAX_LEVEL    = 3
) (
	input  logic                          clk,
	input  logic                          arst_n,
	ibmw_item_if.sink                     item,
	ibmw_result_if.source                 result,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [ibmw_pkg::ADDR_W-1:0]   paddr,
	input  logic [ibmw_pkg::DATA_W-1:0]   pwdata,
	output logic [ibmw_pkg::DATA_W-1:0]   prdata,
	output logic                          pready
);
	import ibmw_pkg::*;

	cfg_t              cfg;
	decode_t           dec;
	result_t           res;

	logic              vld_s1;
	logic              op_s1;
	logic [WORD_W-1:0] logical_blk_s1;
	logic [WORD_W-1:0] pointer_word_s1;
	logic              read_failed_s1;

	logic              vld_s2;
	result_t           res_s2;

	logic              out_free;
	logic              adv;
	logic              take;

	// handshake between the two register stages
	assign out_free   = !vld_s2 || result.ready;
	assign adv        = vld_s1 && out_free;
	assign item.ready = !vld_s1 || adv;
	assign take       = item.valid && item.ready;

	ibmw_cfg #(
		.DIRECT_COUNT (DIRECT_COUNT),
		.INDEX_BITS   (INDEX_BITS)
	) u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (take) begin
			vld_s1 <= 1'b1;
		end else if (adv) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			op_s1           <= item.op;
			logical_blk_s1  <= item.logical_blk;
			pointer_word_s1 <= item.pointer_word;
			read_failed_s1  <= item.read_failed;
		end
	end

	ibmw_decode #(
		.DIRECT_COUNT (DIRECT_COUNT)
	) u_decode (
		.cfg         (cfg),
		.logical_blk (logical_blk_s1),
		.dec         (dec)
	);

	ibmw_walk #(
		.INDEX_BITS (INDEX_BITS),
		.MAX_LEVEL  (MAX_LEVEL)
	) u_walk (
		.clk          (clk),
		.arst_n       (arst_n),
		.adv          (adv),
		.op           (op_s1),
		.pointer_word (pointer_word_s1),
		.read_failed  (read_failed_s1),
		.dec          (dec),
		.res          (res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (out_free) begin
			vld_s2 <= adv && res.has;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && adv) begin
			res_s2 <= res;
		end
	end

	assign result.valid       = vld_s2;
	assign result.kind        = res_s2.kind;
	assign result.table_block = res_s2.table_block;
	assign result.entry_index = res_s2.entry_index;
	assign result.disk_blk    = res_s2.disk_blk;
	assign result.status      = res_s2.status;

endmodule

// ===== tb/indirect_block_map_walker_unit_tb.sv =====
// testbench for indirect_block_map_walker_unit: directed range edges and walk endings,
// then random walks under several table geometries, checked beat by beat against a
// local translation predictor; depends on ibmw_pkg, ibmw_item_if and ibmw_result_if
`timescale 1ns / 100ps

module indirect_block_map_walker_unit_tb;
	import ibmw_pkg::*;

	localparam int DIRECT_COUNT  = 12;
	localparam int INDEX_BITS    = 10;
	localparam int MAX_LEVEL     = 3;
	localparam int SETTLE_CYCLES = 6;
	localparam int HOLD_CYCLES   = 300;
	localparam int LIMIT_CYCLES  = 400000;
	localparam int PHASE_ITEMS   = 118;
	localparam int PRINT_CAP     = 40;

	typedef struct packed {
		kind_t              kind;
		logic [WORD_W-1:0]  table_block;
		logic [ENTRY_W-1:0] entry_index;
		logic [WORD_W-1:0]  disk_blk;
		status_t            status;
	} walk_beat_t;

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [ADDR_W-1:0]  paddr;
	logic [DATA_W-1:0]  pwdata;
	logic [DATA_W-1:0]  prdata;
	logic               pready;

	ibmw_item_if   item_ch();
	ibmw_result_if res_ch();

	indirect_block_map_walker_unit #(
		.DIRECT_COUNT(DIRECT_COUNT),
		.INDEX_BITS  (INDEX_BITS),
		.MAX_LEVEL   (MAX_LEVEL)
	) DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (res_ch),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready)
	);

	// predictor state: register copy and walk progress
	logic [LOG2_W-1:0]  ppb_raw;
	logic               walk_on;
	logic [1:0]         walk_levels;
	logic [1:0]         walk_steps;
	logic [ENTRY_W-1:0] idx_stack [0:3];
	walk_beat_t         walk_beats_due [$];

	int  mismatch_count;
	int  items_sent;
	int  burst_left;
	bit  steady_feed;
	logic hold_req = 1'b0;
	int  hold_left;
	int  rx_mode;
	int  rx_phase_left;
	int  cycle_count;

	// clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("tb: failure");
			$finish;
		end
	end

	function automatic int unsigned eff_log2(logic [LOG2_W-1:0] raw);
		if (raw < 8) return 8;
		if (raw > INDEX_BITS) return INDEX_BITS;
		return raw;
	endfunction

	// first file block of a level under the current geometry; level 4 is beyond range
	function automatic logic [63:0] level_base(int lvl);
		int unsigned l;
		logic [63:0] p;
		l = eff_log2(ppb_raw);
		p = 64'd1 << l;
		case (lvl)
			0: return 64'd0;
			1: return DIRECT_COUNT;
			2: return DIRECT_COUNT + p;
			3: return DIRECT_COUNT + p + (p << l);
			default: return DIRECT_COUNT + p + (p << l) + (p << (2 * l));
		endcase
	endfunction

	function automatic logic [63:0] level_last(int lvl);
		if (lvl >= 4) return 64'hFFFF_FFFF;
		return level_base(lvl + 1) - 1;
	endfunction

	// block number in a level, edges favored
	function automatic logic [WORD_W-1:0] pick_block(int lvl);
		logic [63:0] base;
		logic [63:0] span;
		logic [63:0] off;
		base = level_base(lvl);
		span = level_last(lvl) - base + 1;
		case ($urandom_range(0, 7))
			0: off = 0;
			1: off = span - 1;
			default: off = {$urandom, $urandom} % span;
		endcase
		return WORD_W'(base + off);
	endfunction

	function automatic logic [WORD_W-1:0] nonzero_word();
		logic [WORD_W-1:0] w;
		if ($urandom_range(0, 9) == 0) return '1;
		do w = $urandom; while (w == 0);
		return w;
	endfunction

	function automatic int walk_level();
		case ($urandom_range(0, 9))
			0: return 0;
			1, 2: return 1;
			3, 4: return 2;
			5, 6, 7: return 3;
			default: return 4;
		endcase
	endfunction

	// translation predictor: one accepted beat in, at most one result beat queued
	function automatic void predict_translation(op_t op, logic [WORD_W-1:0] fb,
			logic [WORD_W-1:0] pw, logic rf);
		int unsigned l;
		logic [63:0] b;
		logic [63:0] p;
		logic [63:0] mask;
		int          lvl;
		walk_beat_t  r;
		bit          has;
		has = 0;
		r = '{KIND_READ, '0, '0, '0, ST_MAPPED};
		if (op == OP_REQUEST) begin
			l = eff_log2(ppb_raw);
			p = 64'd1 << l;
			mask = p - 1;
			b = fb;
			walk_on = 1'b0;
			has = 1;
			// split into level and per-level indices
			if (b < DIRECT_COUNT) begin
				lvl = 0;
				idx_stack[0] = b[ENTRY_W-1:0];
			end else begin
				b = b - DIRECT_COUNT;
				if (b < p) begin
					lvl = 1;
					idx_stack[1] = b[ENTRY_W-1:0];
				end else begin
					b = b - p;
					if (b < (p << l)) begin
						lvl = 2;
						idx_stack[1] = ENTRY_W'(b >> l);
						idx_stack[2] = ENTRY_W'(b & mask);
					end else begin
						b = b - (p << l);
						if (b < (p << (2 * l))) begin
							lvl = 3;
							idx_stack[1] = ENTRY_W'(b >> (2 * l));
							idx_stack[2] = ENTRY_W'((b >> l) & mask);
							idx_stack[3] = ENTRY_W'(b & mask);
						end else begin
							lvl = 4;
						end
					end
				end
				if (lvl <= 3) idx_stack[0] = ENTRY_W'(DIRECT_COUNT - 1 + lvl);
			end
			if (lvl > MAX_LEVEL) begin
				r.kind = KIND_DONE;
				r.status = ST_RANGE;
			end else begin
				walk_on = 1'b1;
				walk_levels = 2'(lvl);
				walk_steps = 2'd0;
				r.entry_index = idx_stack[0];
			end
		end else if (walk_on) begin
			has = 1;
			if (rf) begin
				walk_on = 1'b0;
				r.kind = KIND_DONE;
				r.status = ST_RD_ERR;
			end else if (pw == 0) begin
				walk_on = 1'b0;
				r.kind = KIND_DONE;
				r.status = ST_HOLE;
			end else if (walk_steps >= walk_levels) begin
				walk_on = 1'b0;
				r.kind = KIND_DONE;
				r.disk_blk = pw;
			end else begin
				walk_steps = walk_steps + 2'd1;
				r.table_block = pw;
				r.entry_index = idx_stack[walk_steps];
			end
		end
		if (has) walk_beats_due.push_back(r);
	endfunction

	task automatic report_mismatch(string what, logic [WORD_W-1:0] got,
			logic [WORD_W-1:0] want);
		if (mismatch_count < PRINT_CAP)
			$display("mismatch %s: got 0x%0h want 0x%0h at cycle %0d", what, got, want,
				cycle_count);
		mismatch_count++;
	endtask

	// predict on accepted items, check accepted result beats
	always @(posedge clk) begin
		walk_beat_t want;
		if (item_ch.valid === 1'b1 && item_ch.ready === 1'b1)
			predict_translation(op_t'(item_ch.op), item_ch.logical_blk, item_ch.pointer_word,
				item_ch.read_failed);
		if (res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
			if (walk_beats_due.size() == 0) begin
				report_mismatch("unexpected beat", res_ch.disk_blk, '0);
			end else begin
				want = walk_beats_due.pop_front();
				if (res_ch.kind !== want.kind)
					report_mismatch("kind", res_ch.kind, want.kind);
				if (res_ch.table_block !== want.table_block)
					report_mismatch("table_block", res_ch.table_block, want.table_block);
				if (res_ch.entry_index !== want.entry_index)
					report_mismatch("entry_index", res_ch.entry_index, want.entry_index);
				if (res_ch.disk_blk !== want.disk_blk)
					report_mismatch("disk_blk", res_ch.disk_blk, want.disk_blk);
				if (res_ch.status !== want.status)
					report_mismatch("status", res_ch.status, want.status);
			end
		end
	end

	// result side: long hold on request, otherwise a shifting stall pattern
	always @(posedge clk) begin
		if (hold_req) begin
			hold_req <= 1'b0;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			res_ch.ready <= 1'b0;
		end else begin
			if (rx_phase_left == 0) begin
				rx_mode = $urandom_range(0, 3);
				rx_phase_left = $urandom_range(10, 80);
			end
			rx_phase_left--;
			case (rx_mode)
				0: res_ch.ready <= 1'b1;
				1: res_ch.ready <= ($urandom_range(0, 3) != 0);
				2: res_ch.ready <= 1'($urandom_range(0, 1));
				default: res_ch.ready <= ((rx_phase_left % 7) < 3);
			endcase
		end
	end

	// one item beat, with a random gap at the start of each burst unless steady_feed is set
	task automatic send_item(op_t op, logic [WORD_W-1:0] fb, logic [WORD_W-1:0] pw,
			logic rf);
		int gap;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 12)
				: $urandom_range(20, 60);
			if (!steady_feed) begin
				gap = $urandom_range(1, 8);
				item_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		item_ch.valid <= 1'b1;
		item_ch.op <= op;
		item_ch.logical_blk <= fb;
		item_ch.pointer_word <= pw;
		item_ch.read_failed <= rf;
		do @(posedge clk); while (item_ch.ready !== 1'b1);
		burst_left--;
		items_sent++;
	endtask

	// stop feeding and wait for every due beat plus pipeline drain
	task automatic wait_idle();
		item_ch.valid <= 1'b0;
		burst_left = 0;
		do @(posedge clk); while (walk_beats_due.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// apb write of the pointers-per-block register, random upper data bits
	task automatic write_ppb_log2(logic [LOG2_W-1:0] val);
		logic [DATA_W-1:0] data;
		data = $urandom;
		data[LOG2_W-1:0] = val;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {REG_PPB_LOG2, 2'b00};
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		ppb_raw = data[LOG2_W-1:0];
	endtask

	// one walk: request then pointer words, unclean walks may end early
	task automatic run_walk(int lvl, bit clean);
		int roll;
		send_item(OP_REQUEST, pick_block(lvl), $urandom, 1'($urandom_range(0, 1)));
		if (lvl > MAX_LEVEL) return;
		for (int s = 0; s <= lvl; s++) begin
			roll = $urandom_range(0, 99);
			if (!clean && roll < 5) begin
				send_item(OP_POINTER, $urandom, $urandom, 1'b1);
				return;
			end
			if (!clean && roll < 10) begin
				send_item(OP_POINTER, $urandom, '0, 1'b0);
				return;
			end
			// abandoned walk, the next request drops it
			if (!clean && roll < 13) return;
			send_item(OP_POINTER, $urandom, nonzero_word(), 1'b0);
		end
		// stray word after the walk ended
		if ($urandom_range(0, 19) == 0)
			send_item(OP_POINTER, $urandom, $urandom, 1'($urandom_range(0, 1)));
	endtask

	task automatic random_traffic(int count);
		int stop_at;
		int pick;
		stop_at = items_sent + count;
		while (items_sent < stop_at) begin
			pick = $urandom_range(0, 99);
			if (pick < 88) run_walk(walk_level(), pick < 30);
			else send_item(op_t'($urandom_range(0, 1)), $urandom, $urandom,
				1'($urandom_range(0, 1)));
		end
	endtask

	// first and last block of every level, each request dropping the one before
	task automatic test_level_edges();
		for (int lvl = 0; lvl <= 4; lvl++) begin
			send_item(OP_REQUEST, WORD_W'(level_base(lvl)), '0, 1'b0);
			send_item(OP_REQUEST, WORD_W'(level_last(lvl)), '1, 1'b1);
		end
	endtask

	// mapped, hole, read error and stray-word endings
	task automatic test_walk_endings();
		send_item(OP_REQUEST, '0, '0, 1'b0);
		send_item(OP_POINTER, '0, '1, 1'b0);
		send_item(OP_REQUEST, WORD_W'(level_base(1)), '0, 1'b0);
		send_item(OP_POINTER, '0, 32'd5, 1'b0);
		send_item(OP_POINTER, '1, '0, 1'b0);
		send_item(OP_REQUEST, WORD_W'(level_base(2) + 1), '0, 1'b0);
		send_item(OP_POINTER, '0, 32'hA5A5_5A5A, 1'b1);
		send_item(OP_POINTER, '1, 32'h1234_5678, 1'b0);
		send_item(OP_REQUEST, WORD_W'(DIRECT_COUNT - 1), '0, 1'b0);
		send_item(OP_POINTER, '0, '0, 1'b0);
		send_item(OP_REQUEST, WORD_W'(level_last(3)), '0, 1'b0);
		send_item(OP_POINTER, '0, 32'hFFFF_FFFF, 1'b0);
		send_item(OP_POINTER, '0, 32'h8000_0000, 1'b0);
		send_item(OP_POINTER, '0, 32'h0000_0001, 1'b0);
		send_item(OP_POINTER, '0, 32'h7FFF_FFFF, 1'b0);
	endtask

	// random walks under a series of register settings, extremes included
	task automatic test_geometry_sweep();
		logic [LOG2_W-1:0] settings [0:7];
		settings = '{4'd10, 4'd9, 4'd0, 4'd15, 4'd7, 4'd11, 4'd8, 4'd8};
		settings[7] = $urandom_range(0, 15);
		random_traffic(PHASE_ITEMS);
		foreach (settings[i]) begin
			wait_idle();
			write_ppb_log2(settings[i]);
			random_traffic(PHASE_ITEMS);
		end
	endtask

	// long result hold while the sender keeps offering, so the input stalls
	task automatic test_backpressure_fill();
		wait_idle();
		write_ppb_log2(4'd10);
		steady_feed = 1;
		hold_req <= 1'b1;
		random_traffic(60);
		steady_feed = 0;
		wait_idle();
	endtask

	initial begin
		arst_n = 1'b0;
		item_ch.valid = 1'b0;
		item_ch.op = OP_REQUEST;
		item_ch.logical_blk = '0;
		item_ch.pointer_word = '0;
		item_ch.read_failed = 1'b0;
		res_ch.ready = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		ppb_raw = LOG2_RESET;
		walk_on = 1'b0;
		walk_levels = '0;
		walk_steps = '0;
		mismatch_count = 0;
		items_sent = 0;
		burst_left = 0;
		steady_feed = 0;
		hold_left = 0;
		rx_mode = 0;
		rx_phase_left = 0;
		cycle_count = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_level_edges();
		test_walk_endings();
		wait_idle();
		test_geometry_sweep();
		test_backpressure_fill();
		wait_idle();

		if (mismatch_count == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

// ===== indirect_block_map_walker_unit.f =====
hw/rtl/ibmw_pkg.sv
hw/rtl/ibmw_item_if.sv
hw/rtl/ibmw_result_if.sv
hw/rtl/ibmw_cfg.sv
hw/rtl/ibmw_decode.sv
hw/rtl/ibmw_walk.sv
hw/rtl/indirect_block_map_walker_unit.sv
tb/indirect_block_map_walker_unit_tb.sv
